FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the validator RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/jsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON syntax validator package
// Shared types, scanner states, character codes and literal tables.
// ----------------------------------------------------------------------------
package jsv_pkg;

    localparam int MAX_NESTING_DEF = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] value_type;
    } out_item_t;

    // Type codes of the top-level value.
    localparam logic [2:0] VT_BAD    = 3'd0;
    localparam logic [2:0] VT_OBJECT = 3'd1;
    localparam logic [2:0] VT_ARRAY  = 3'd2;
    localparam logic [2:0] VT_STRING = 3'd3;
    localparam logic [2:0] VT_TRUE   = 3'd4;
    localparam logic [2:0] VT_FALSE  = 3'd5;
    localparam logic [2:0] VT_NULL   = 3'd6;
    localparam logic [2:0] VT_NUMBER = 3'd7;

    typedef enum logic [4:0] {
        ST_VALUE       = 5'd0,
        ST_VALUE_CLOSE = 5'd1,
        ST_KEY_CLOSE   = 5'd2,
        ST_KEY         = 5'd3,
        ST_COLON       = 5'd4,
        ST_AFTER       = 5'd5,
        ST_VSTR        = 5'd6,
        ST_VESC        = 5'd7,
        ST_VHEX        = 5'd8,
        ST_KSTR        = 5'd9,
        ST_KESC        = 5'd10,
        ST_KHEX        = 5'd11,
        ST_N_MINUS     = 5'd12,
        ST_N_ZERO      = 5'd13,
        ST_N_INT       = 5'd14,
        ST_N_DOT       = 5'd15,
        ST_N_FRAC      = 5'd16,
        ST_N_E         = 5'd17,
        ST_N_ESIGN     = 5'd18,
        ST_N_EXP       = 5'd19,
        ST_LIT_TRUE    = 5'd20,
        ST_LIT_FALSE   = 5'd21,
        ST_LIT_NULL    = 5'd22
    } scan_state_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Length of the literal "true", "false" or "null".
    function automatic logic [2:0] lit_len(input logic [1:0] sel);
        logic [2:0] len;
        unique case (sel)
            LIT_FALSE: len = 3'd5;
            LIT_TRUE,
            LIT_NULL:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Character at position pos of the selected literal; zero past its end.
    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (sel)
            LIT_TRUE: begin
                unique case (pos)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                unique case (pos)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            end
            LIT_NULL: begin
                unique case (pos)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/jsv_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSV stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface jsv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/jsv_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSV scanner
// Grammar state, nesting stack and verdict for one document byte per cycle while step is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsv_scanner #(
    parameter int MAX_NESTING = jsv_pkg::MAX_NESTING_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire jsv_pkg::in_item_t   item,
    output jsv_pkg::out_item_t       verdict
);

    localparam int LVL_W = $clog2(MAX_NESTING + 1);

    jsv_pkg::scan_state_t   state_reg, st_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    logic [2:0]             sub_reg, sub_next;
    logic [2:0]             top_reg, top_next;
    logic                   err_reg, err_next;
    // Stack of open containers as a shift line: bit 0 is the innermost one.
    logic [MAX_NESTING-1:0] stack_reg, stack_next;

    logic [7:0] c;
    logic       is_ws, is_dig, is_hx, is_e;
    logic [2:0] bv_type;
    logic       push, push_obj, pop;
    logic       req_begin, req_after, req_close;
    logic [1:0] lit_sel;
    logic [2:0] lit_l;
    logic [2:0] sub_dec, sub_inc;
    logic       in_key;
    logic       ok;

    assign c      = item.data_byte;
    assign is_ws  = (c == jsv_pkg::CH_SPACE) || (c == jsv_pkg::CH_TAB) ||
                    (c == jsv_pkg::CH_LF) || (c == jsv_pkg::CH_CR);
    assign is_dig = (c >= jsv_pkg::CH_ZERO) && (c <= jsv_pkg::CH_NINE);
    assign is_hx  = is_dig || ((c >= jsv_pkg::CH_LO_A) && (c <= jsv_pkg::CH_LO_F)) ||
                    ((c >= jsv_pkg::CH_UP_A) && (c <= jsv_pkg::CH_UP_F));
    assign is_e   = (c == jsv_pkg::CH_LO_E) || (c == jsv_pkg::CH_UP_E);
    assign sub_dec = sub_reg - 3'd1;
    assign sub_inc = sub_reg + 3'd1;

    always_comb
    begin
        priority if (c == jsv_pkg::CH_LBRACE)          bv_type = jsv_pkg::VT_OBJECT;
        else if (c == jsv_pkg::CH_LBRACK)              bv_type = jsv_pkg::VT_ARRAY;
        else if (c == jsv_pkg::CH_QUOTE)               bv_type = jsv_pkg::VT_STRING;
        else if (c == jsv_pkg::CH_LO_T)                bv_type = jsv_pkg::VT_TRUE;
        else if (c == jsv_pkg::CH_LO_F)                bv_type = jsv_pkg::VT_FALSE;
        else if (c == jsv_pkg::CH_LO_N)                bv_type = jsv_pkg::VT_NULL;
        else if (c == jsv_pkg::CH_MINUS || is_dig)     bv_type = jsv_pkg::VT_NUMBER;
        else                                           bv_type = jsv_pkg::VT_BAD;
    end

    always_comb
    begin
        unique case (state_reg)
            jsv_pkg::ST_LIT_FALSE: lit_sel = jsv_pkg::LIT_FALSE;
            jsv_pkg::ST_LIT_NULL:  lit_sel = jsv_pkg::LIT_NULL;
            default:               lit_sel = jsv_pkg::LIT_TRUE;
        endcase
    end
    assign lit_l  = jsv_pkg::lit_len(lit_sel);
    assign in_key = (state_reg == jsv_pkg::ST_KSTR) || (state_reg == jsv_pkg::ST_KESC) ||
                    (state_reg == jsv_pkg::ST_KHEX);

    // Next grammar state for the current byte. Bytes after an error change nothing.
    always_comb
    begin
        st_next    = state_reg;
        level_next = level_reg;
        sub_next   = sub_reg;
        top_next   = top_reg;
        err_next   = err_reg;
        push       = 1'b0;
        push_obj   = 1'b0;
        pop        = 1'b0;
        req_begin  = 1'b0;
        req_after  = 1'b0;
        req_close  = 1'b0;

        if (!err_reg)
        begin
            unique case (state_reg)
                jsv_pkg::ST_VALUE:
                begin
                    if (!is_ws)
                        req_begin = 1'b1;
                end
                jsv_pkg::ST_VALUE_CLOSE:
                begin
                    if (!is_ws)
                    begin
                        if (c == jsv_pkg::CH_RBRACK)
                            req_close = 1'b1;
                        else
                            req_begin = 1'b1;
                    end
                end
                jsv_pkg::ST_KEY_CLOSE,
                jsv_pkg::ST_KEY:
                begin
                    if (!is_ws)
                    begin
                        if (c == jsv_pkg::CH_RBRACE && state_reg == jsv_pkg::ST_KEY_CLOSE)
                            req_close = 1'b1;
                        else if (c == jsv_pkg::CH_QUOTE)
                            st_next = jsv_pkg::ST_KSTR;
                        else
                            err_next = 1'b1;
                    end
                end
                jsv_pkg::ST_COLON:
                begin
                    if (!is_ws)
                    begin
                        if (c == jsv_pkg::CH_COLON)
                            st_next = jsv_pkg::ST_VALUE;
                        else
                            err_next = 1'b1;
                    end
                end
                jsv_pkg::ST_AFTER:
                begin
                    req_after = 1'b1;
                end
                jsv_pkg::ST_VSTR,
                jsv_pkg::ST_KSTR:
                begin
                    if (c == jsv_pkg::CH_QUOTE)
                        st_next = in_key ? jsv_pkg::ST_COLON : jsv_pkg::ST_AFTER;
                    else if (c < jsv_pkg::CH_SPACE)
                        err_next = 1'b1;
                    else if (c == jsv_pkg::CH_BSLASH)
                        st_next = in_key ? jsv_pkg::ST_KESC : jsv_pkg::ST_VESC;
                end
                jsv_pkg::ST_VESC,
                jsv_pkg::ST_KESC:
                begin
                    if (c == jsv_pkg::CH_LO_U)
                    begin
                        sub_next = 3'd4;
                        st_next  = in_key ? jsv_pkg::ST_KHEX : jsv_pkg::ST_VHEX;
                    end
                    else if (c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_BSLASH ||
                             c == jsv_pkg::CH_SLASH || c == jsv_pkg::CH_LO_B ||
                             c == jsv_pkg::CH_LO_F || c == jsv_pkg::CH_LO_N ||
                             c == jsv_pkg::CH_LO_R || c == jsv_pkg::CH_LO_T)
                        st_next = in_key ? jsv_pkg::ST_KSTR : jsv_pkg::ST_VSTR;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::ST_VHEX,
                jsv_pkg::ST_KHEX:
                begin
                    if (!is_hx)
                        err_next = 1'b1;
                    else
                    begin
                        sub_next = sub_dec;
                        if (sub_dec == 3'd0)
                            st_next = in_key ? jsv_pkg::ST_KSTR : jsv_pkg::ST_VSTR;
                    end
                end
                jsv_pkg::ST_N_MINUS:
                begin
                    if (c == jsv_pkg::CH_ZERO)
                        st_next = jsv_pkg::ST_N_ZERO;
                    else if (is_dig)
                        st_next = jsv_pkg::ST_N_INT;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::ST_N_ZERO,
                jsv_pkg::ST_N_INT:
                begin
                    if (state_reg == jsv_pkg::ST_N_INT && is_dig)
                        st_next = state_reg;
                    else if (c == jsv_pkg::CH_DOT)
                        st_next = jsv_pkg::ST_N_DOT;
                    else if (is_e)
                        st_next = jsv_pkg::ST_N_E;
                    else
                    begin
                        st_next   = jsv_pkg::ST_AFTER;
                        req_after = 1'b1;
                    end
                end
                jsv_pkg::ST_N_DOT:
                begin
                    if (is_dig)
                        st_next = jsv_pkg::ST_N_FRAC;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::ST_N_FRAC:
                begin
                    if (is_dig)
                        st_next = state_reg;
                    else if (is_e)
                        st_next = jsv_pkg::ST_N_E;
                    else
                    begin
                        st_next   = jsv_pkg::ST_AFTER;
                        req_after = 1'b1;
                    end
                end
                jsv_pkg::ST_N_E:
                begin
                    if (c == jsv_pkg::CH_PLUS || c == jsv_pkg::CH_MINUS)
                        st_next = jsv_pkg::ST_N_ESIGN;
                    else if (is_dig)
                        st_next = jsv_pkg::ST_N_EXP;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::ST_N_ESIGN:
                begin
                    if (is_dig)
                        st_next = jsv_pkg::ST_N_EXP;
                    else
                        err_next = 1'b1;
                end
                jsv_pkg::ST_N_EXP:
                begin
                    if (!is_dig)
                    begin
                        st_next   = jsv_pkg::ST_AFTER;
                        req_after = 1'b1;
                    end
                end
                jsv_pkg::ST_LIT_TRUE,
                jsv_pkg::ST_LIT_FALSE,
                jsv_pkg::ST_LIT_NULL:
                begin
                    if (sub_reg >= lit_l || c != jsv_pkg::lit_char(lit_sel, sub_reg))
                        err_next = 1'b1;
                    else
                    begin
                        sub_next = sub_inc;
                        if (sub_inc == lit_l)
                            st_next = jsv_pkg::ST_AFTER;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase

            // Separator or closing bracket after a complete value.
            if (req_after && !is_ws)
            begin
                if (level_reg == '0)
                    err_next = 1'b1;
                else if (c == jsv_pkg::CH_COMMA)
                    st_next = stack_reg[0] ? jsv_pkg::ST_KEY : jsv_pkg::ST_VALUE;
                else if (c == jsv_pkg::CH_RBRACE || c == jsv_pkg::CH_RBRACK)
                    req_close = 1'b1;
                else
                    err_next = 1'b1;
            end

            // The bracket must match the innermost open container.
            if (req_close)
            begin
                if (level_reg == '0 || stack_reg[0] != (c == jsv_pkg::CH_RBRACE))
                    err_next = 1'b1;
                else
                begin
                    level_next = level_reg - LVL_W'(1);
                    pop        = 1'b1;
                    st_next    = jsv_pkg::ST_AFTER;
                end
            end

            if (req_begin)
            begin
                if (bv_type == jsv_pkg::VT_BAD)
                    err_next = 1'b1;
                else
                begin
                    if (level_reg == '0)
                        top_next = bv_type;
                    sub_next = 3'd1;
                    unique case (bv_type)
                        jsv_pkg::VT_OBJECT,
                        jsv_pkg::VT_ARRAY:
                        begin
                            if (level_reg >= LVL_W'(MAX_NESTING))
                                err_next = 1'b1;
                            else
                            begin
                                push       = 1'b1;
                                push_obj   = (bv_type == jsv_pkg::VT_OBJECT);
                                level_next = level_reg + LVL_W'(1);
                                st_next    = (bv_type == jsv_pkg::VT_OBJECT) ?
                                             jsv_pkg::ST_KEY_CLOSE : jsv_pkg::ST_VALUE_CLOSE;
                            end
                        end
                        jsv_pkg::VT_STRING: st_next = jsv_pkg::ST_VSTR;
                        jsv_pkg::VT_TRUE:   st_next = jsv_pkg::ST_LIT_TRUE;
                        jsv_pkg::VT_FALSE:  st_next = jsv_pkg::ST_LIT_FALSE;
                        jsv_pkg::VT_NULL:   st_next = jsv_pkg::ST_LIT_NULL;
                        default:
                        begin
                            if (c == jsv_pkg::CH_MINUS)
                                st_next = jsv_pkg::ST_N_MINUS;
                            else if (c == jsv_pkg::CH_ZERO)
                                st_next = jsv_pkg::ST_N_ZERO;
                            else
                                st_next = jsv_pkg::ST_N_INT;
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        stack_next = stack_reg;
        if (push)
        begin
            stack_next    = stack_reg << 1;
            stack_next[0] = push_obj;
        end
        else if (pop)
            stack_next = stack_reg >> 1;
    end

    // A document ends well only outside all containers, after a value or inside
    // a number that may legally stop here.
    assign ok = !err_next && (level_next == '0) &&
                (st_next == jsv_pkg::ST_AFTER || st_next == jsv_pkg::ST_N_ZERO ||
                 st_next == jsv_pkg::ST_N_INT || st_next == jsv_pkg::ST_N_FRAC ||
                 st_next == jsv_pkg::ST_N_EXP);

    assign verdict.valid_res  = ok;
    assign verdict.value_type = ok ? top_next : jsv_pkg::VT_BAD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jsv_pkg::ST_VALUE;
            level_reg <= '0;
            sub_reg   <= '0;
            top_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                state_reg <= jsv_pkg::ST_VALUE;
                level_reg <= '0;
                sub_reg   <= '0;
                top_reg   <= '0;
                err_reg   <= 1'b0;
            end
            else
            begin
                state_reg <= st_next;
                level_reg <= level_next;
                sub_reg   <= sub_next;
                top_reg   <= top_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            stack_reg <= stack_next;
    end

    `ASSERT_ALWAYS(a_level_bound, level_reg <= LVL_W'(MAX_NESTING), "nesting level over limit")
    `ASSERT_NEXT(a_restart, step && item.last,
                 state_reg == jsv_pkg::ST_VALUE && level_reg == '0 && !err_reg,
                 "scanner did not restart after the final byte")

endmodule
`default_nettype wire

FILE: hw/rtl/json_syntax_validator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON syntax validator core
// Strict JSON syntax check of a byte stream with one verdict per document.
// ----------------------------------------------------------------------------
// The block takes one document byte per cycle on doc and gives one result on
// result for each byte marked last: valid_res and the type of the top-level
// value. A byte waits in the input register while the scanner works on it, and
// the result of a final byte is loaded into the output register as that byte
// moves on. The rate of one byte per cycle holds but for the stall below.
// Only a final byte is held back, and only while an earlier result still sits
// unread in the output register. Open containers are kept in a MAX_NESTING
// deep shift line, so no clearing is needed after reset.
`include "assert_macros.svh"

module json_syntax_validator_core #(
    parameter int MAX_NESTING = jsv_pkg::MAX_NESTING_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    jsv_stream_if.sink   doc,
    jsv_stream_if.source result
);

    logic               in_vld_reg;
    jsv_pkg::in_item_t  in_item_reg;
    logic               out_vld_reg;
    jsv_pkg::out_item_t out_item_reg;
    jsv_pkg::out_item_t verdict;
    logic               adv;

    // A byte moves on unless it must hand a result to a full output register.
    assign adv = in_vld_reg && (!in_item_reg.last || !out_vld_reg || result.ready);
    assign doc.ready = !in_vld_reg || adv;

    assign result.valid   = out_vld_reg;
    assign result.payload = out_item_reg;

    jsv_scanner #(
        .MAX_NESTING (MAX_NESTING)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (doc.ready)
                in_vld_reg <= doc.valid;
            if (adv && in_item_reg.last)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (doc.ready && doc.valid)
            in_item_reg <= doc.payload;
        if (adv && in_item_reg.last)
            out_item_reg <= verdict;
    end

    `ASSERT_NEXT(a_result_loaded, adv && in_item_reg.last, out_vld_reg,
                 "final byte produced no result")
    `ASSERT_IMPLIES(a_type_matches, out_vld_reg,
                    out_item_reg.valid_res == (out_item_reg.value_type != jsv_pkg::VT_BAD),
                    "value type disagrees with validity")

endmodule
`default_nettype wire
